[rtl/core/pot_median_smooth_quantizer_defines.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the pot conditioning core.
// ----------------------------------------------------------------------------
`ifndef POT_MEDIAN_SMOOTH_QUANTIZER_DEFINES_SVH
`define POT_MEDIAN_SMOOTH_QUANTIZER_DEFINES_SVH

// property holds on every edge out of reset
`define PMSQ_ASSERT_HOLD(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// consequent holds in the cycle after the antecedent
`define PMSQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/pmsq_pkg.sv]
// ----------------------------------------------------------------------------
// pmsq_pkg
// Types and constants of the pot median / smoother / quantizer core.
// ----------------------------------------------------------------------------
package pmsq_pkg;

    localparam int unsigned STEP_COUNT_DEF = 127;

    localparam int unsigned CFG_ADDR_W = 8;
    localparam int unsigned CFG_DATA_W = 32;
    localparam int unsigned S_DATA_W   = 16;
    localparam int unsigned M_DATA_W   = 32;

    localparam int unsigned LVL_W   = 17;
    localparam int unsigned GAIN_W  = 18;
    localparam int unsigned WARM_W  = 16;
    localparam int unsigned STEP_W  = 7;
    localparam int unsigned MULA_W  = 19;
    localparam int unsigned MULP_W  = 20;
    localparam int unsigned MUL_STEPS = 17;
    localparam int unsigned CNT_W   = 5;

    localparam logic [LVL_W-1:0]  ONE_Q16    = 17'h10000;
    localparam logic [GAIN_W-1:0] GAIN_RST   = 18'd81340;
    localparam logic [LVL_W-1:0]  COEFF_RST  = 17'h10000;
    localparam logic [WARM_W-1:0] WARMUP_RST = 16'd2756;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_INPUT_GAIN   = 8'd0,
        REG_REVERSE_DIR  = 8'd1,
        REG_SMOOTH_COEFF = 8'd2,
        REG_WARMUP_LEN   = 8'd3
    } reg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MAP,
        ST_MED,
        ST_FILT,
        ST_LEVEL,
        ST_QUANT,
        ST_DONE
    } state_t;

    function automatic logic [LVL_W-1:0] med3(input logic [LVL_W-1:0] a,
                                             input logic [LVL_W-1:0] b,
                                             input logic [LVL_W-1:0] c);
        logic [LVL_W-1:0] lo;
        logic [LVL_W-1:0] hi;
        lo = (a < b) ? a : b;
        hi = (a < b) ? b : a;
        if (c <= lo) begin
            med3 = lo;
        end else if (c >= hi) begin
            med3 = hi;
        end else begin
            med3 = c;
        end
    endfunction

endpackage

[rtl/core/pot_median_smooth_quantizer.sv]
// ----------------------------------------------------------------------------
// pot_median_smooth_quantizer
// Pot reading conditioner: gain map, median of three, one-pole smoother,
// step quantizer with warm-up suppression and a poll-and-clear change flag.
// ----------------------------------------------------------------------------
// A sample beat runs the map, median, filter, level and quantize steps before
// its result is registered; a poll beat goes straight to its result. No new
// beat is taken until the last result is registered. One bit-serial shift-add
// multiplier runs three passes per sample (gain map, smoothing product, step scaling).
// aresetn is synchronous, active low; it loads register defaults and clears
// history, filter level, step and flag. No clearing pass.
`include "pot_median_smooth_quantizer_defines.svh"

module pot_median_smooth_quantizer #(
    parameter int unsigned STEP_COUNT = pmsq_pkg::STEP_COUNT_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [pmsq_pkg::S_DATA_W-1:0]     s_tdata,   // [15:0] adc_sample
    input  logic                              s_tuser,   // [0] req_type
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [6:0] step_value, [23:7] smoothed_level, [24] change_flag,
    // [25] warming_up, [31:26] zero
    output logic [pmsq_pkg::M_DATA_W-1:0]     m_tdata,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [pmsq_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  logic [pmsq_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import pmsq_pkg::*;

    localparam logic [MULA_W-1:0] STEP_MULT = MULA_W'(STEP_COUNT);
    localparam logic [STEP_W-1:0] STEP_CODE = STEP_W'(STEP_COUNT);

    state_t state_reg, state_next;

    logic [GAIN_W-1:0]        gain_reg,   gain_next;
    logic                     rev_reg,    rev_next;
    logic [LVL_W-1:0]         coeff_reg,  coeff_next;
    logic [WARM_W-1:0]        wlen_reg,   wlen_next;
    logic [LVL_W-1:0]         hist0_reg,  hist0_next;
    logic [LVL_W-1:0]         hist1_reg,  hist1_next;
    logic [LVL_W-1:0]         hist2_reg,  hist2_next;
    logic [LVL_W-1:0]         level_reg,  level_next;
    logic [STEP_W-1:0]        step_reg,   step_next;
    logic                     pend_reg,   pend_next;
    logic                     wact_reg,   wact_next;
    logic [WARM_W-1:0]        wrem_reg,   wrem_next;
    logic                     req_reg,    req_next;
    logic [MULA_W-1:0]        mul_a_reg,  mul_a_next;
    logic [MULP_W-1:0]        mul_p_reg,  mul_p_next;
    logic [MUL_STEPS-1:0]     mul_q_reg,  mul_q_next;
    logic [CNT_W-1:0]         cnt_reg,    cnt_next;
    logic                     mvalid_reg, mvalid_next;
    logic [M_DATA_W-1:0]      mdata_reg,  mdata_next;

    logic                     s_beat;
    logic                     mul_last;
    logic                     out_free;
    logic signed [MULP_W-1:0] mul_sum;
    logic [MULP_W:0]          prod_hi;
    logic signed [MULP_W+MUL_STEPS-1:0] prod_rnd;
    logic [GAIN_W-1:0]        mapped;
    logic signed [MULA_W-1:0] rev_val;
    logic [LVL_W-1:0]         samp_new;
    logic [LVL_W-1:0]         med;
    logic signed [LVL_W:0]    diff;
    logic signed [MULP_W+1:0] lvl_sum;
    logic [LVL_W-1:0]         lvl_clamp;
    logic [STEP_W-1:0]        new_step;
    logic                     flag_out;

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = mvalid_reg;
    assign m_tdata   = mdata_reg;
    assign s_beat    = s_tvalid && s_tready;
    assign mul_last  = (cnt_reg == CNT_W'(MUL_STEPS - 1));
    assign out_free  = !mvalid_reg || m_tready;

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_beat) begin
                    state_next = s_tuser ? ST_DONE : ST_MAP;
                end
            end
            ST_MAP: begin
                if (mul_last) state_next = ST_MED;
            end
            ST_MED:   state_next = ST_FILT;
            ST_FILT: begin
                if (mul_last) state_next = ST_LEVEL;
            end
            ST_LEVEL: state_next = ST_QUANT;
            ST_QUANT: begin
                if (mul_last) state_next = ST_DONE;
            end
            ST_DONE: begin
                if (out_free) state_next = ST_IDLE;
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    // shared arithmetic
    always_comb begin
        mul_sum  = mul_q_reg[0]
                 ? $signed(mul_p_reg) + $signed({mul_a_reg[MULA_W-1], mul_a_reg})
                 : $signed(mul_p_reg);
        prod_hi  = {mul_p_reg, mul_q_reg[MUL_STEPS-1]};
        prod_rnd = $signed({mul_p_reg, mul_q_reg}) + (MULP_W+MUL_STEPS)'(32768);

        mapped  = prod_hi[GAIN_W-1:0];
        rev_val = $signed(MULA_W'(ONE_Q16)) - $signed({1'b0, mapped});
        if (rev_reg) begin
            samp_new = rev_val[MULA_W-1] ? '0 : rev_val[LVL_W-1:0];
        end else begin
            samp_new = (mapped > GAIN_W'(ONE_Q16)) ? ONE_Q16 : mapped[LVL_W-1:0];
        end
        med  = med3(samp_new, hist0_reg, hist1_reg);
        diff = $signed({1'b0, med}) - $signed({1'b0, level_reg});

        lvl_sum = $signed({5'b0, level_reg})
                + $signed({prod_rnd[MULP_W+MUL_STEPS-1], prod_rnd[MULP_W+MUL_STEPS-1:16]});
        if (lvl_sum[MULP_W+1]) begin
            lvl_clamp = '0;
        end else if (lvl_sum > (MULP_W+2)'(ONE_Q16)) begin
            lvl_clamp = ONE_Q16;
        end else begin
            lvl_clamp = lvl_sum[LVL_W-1:0];
        end

        new_step = (level_reg >= ONE_Q16) ? STEP_CODE : prod_hi[STEP_W-1:0];
    end

    // datapath and outputs
    always_comb begin
        gain_next   = gain_reg;
        rev_next    = rev_reg;
        coeff_next  = coeff_reg;
        wlen_next   = wlen_reg;
        hist0_next  = hist0_reg;
        hist1_next  = hist1_reg;
        hist2_next  = hist2_reg;
        level_next  = level_reg;
        step_next   = step_reg;
        pend_next   = pend_reg;
        wact_next   = wact_reg;
        wrem_next   = wrem_reg;
        req_next    = req_reg;
        mul_a_next  = mul_a_reg;
        mul_p_next  = mul_p_reg;
        mul_q_next  = mul_q_reg;
        cnt_next    = cnt_reg;
        mvalid_next = mvalid_reg && !m_tready;
        mdata_next  = mdata_reg;
        flag_out    = pend_reg;

        if (cfg_valid) begin
            unique case (cfg_addr)
                REG_INPUT_GAIN:   gain_next = cfg_data[GAIN_W-1:0];
                REG_REVERSE_DIR:  rev_next  = cfg_data[0];
                REG_SMOOTH_COEFF: begin
                    coeff_next = (cfg_data[LVL_W-1:0] > ONE_Q16) ? ONE_Q16
                                                                 : cfg_data[LVL_W-1:0];
                end
                REG_WARMUP_LEN: begin
                    wlen_next = cfg_data[WARM_W-1:0];
                    wrem_next = cfg_data[WARM_W-1:0];
                    wact_next = (cfg_data[WARM_W-1:0] != '0);
                end
                default: ;
            endcase
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_beat) begin
                    req_next   = s_tuser;
                    mul_a_next = {1'b0, gain_reg};
                    mul_p_next = '0;
                    mul_q_next = {1'b0, s_tdata};
                    cnt_next   = '0;
                end
            end
            ST_MAP, ST_FILT, ST_QUANT: begin
                mul_p_next = {mul_sum[MULP_W-1], mul_sum[MULP_W-1:1]};
                mul_q_next = {mul_sum[0], mul_q_reg[MUL_STEPS-1:1]};
                cnt_next   = cnt_reg + 1'b1;
            end
            ST_MED: begin
                hist0_next = samp_new;
                hist1_next = hist0_reg;
                hist2_next = hist1_reg;
                mul_a_next = {diff[LVL_W], diff};
                mul_p_next = '0;
                mul_q_next = coeff_reg;
                cnt_next   = '0;
            end
            ST_LEVEL: begin
                level_next = lvl_clamp;
                mul_a_next = STEP_MULT;
                mul_p_next = '0;
                mul_q_next = lvl_clamp;
                cnt_next   = '0;
            end
            ST_DONE: begin
                if (out_free) begin
                    if (req_reg) begin
                        flag_out  = pend_reg;
                        pend_next = 1'b0;
                    end else begin
                        if (wact_reg) begin
                            if (wrem_reg != '0) begin
                                wrem_next = wrem_reg - 1'b1;
                            end else begin
                                wact_next = 1'b0;
                                step_next = new_step;
                                pend_next = 1'b1;
                            end
                        end else if (new_step != step_reg) begin
                            step_next = new_step;
                            pend_next = 1'b1;
                        end
                        flag_out = pend_next;
                    end
                    mvalid_next = 1'b1;
                    mdata_next  = {6'b0, wact_next, flag_out, level_reg, step_next};
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            gain_reg   <= GAIN_RST;
            rev_reg    <= 1'b0;
            coeff_reg  <= COEFF_RST;
            wlen_reg   <= WARMUP_RST;
            hist0_reg  <= '0;
            hist1_reg  <= '0;
            hist2_reg  <= '0;
            level_reg  <= '0;
            step_reg   <= '0;
            pend_reg   <= 1'b0;
            wact_reg   <= (WARMUP_RST != '0);
            wrem_reg   <= WARMUP_RST;
            req_reg    <= 1'b0;
            cnt_reg    <= '0;
            mvalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            gain_reg   <= gain_next;
            rev_reg    <= rev_next;
            coeff_reg  <= coeff_next;
            wlen_reg   <= wlen_next;
            hist0_reg  <= hist0_next;
            hist1_reg  <= hist1_next;
            hist2_reg  <= hist2_next;
            level_reg  <= level_next;
            step_reg   <= step_next;
            pend_reg   <= pend_next;
            wact_reg   <= wact_next;
            wrem_reg   <= wrem_next;
            req_reg    <= req_next;
            cnt_reg    <= cnt_next;
            mvalid_reg <= mvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        mul_a_reg <= mul_a_next;
        mul_p_reg <= mul_p_next;
        mul_q_reg <= mul_q_next;
        mdata_reg <= mdata_next;
    end

    `PMSQ_ASSERT_HOLD(a_level_in_range, aclk, aresetn, level_reg <= ONE_Q16,
        "filter level above one")
    `PMSQ_ASSERT_HOLD(a_warmup_done_empty, aclk, aresetn, wact_reg || (wrem_reg == '0),
        "warm-up ended with count left")
    `PMSQ_ASSERT_NEXT(a_beat_leaves_idle, aclk, aresetn, s_beat, state_reg != ST_IDLE,
        "input beat did not start work")
    `PMSQ_ASSERT_HOLD(a_hist_in_range, aclk, aresetn,
        (hist2_reg <= ONE_Q16) && (hist0_reg <= ONE_Q16), "history sample above one")

endmodule

[bench/tb_pot_median_smooth_quantizer.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_pot_median_smooth_quantizer
// Self-checking bench for the pot conditioner. A cycle-free model of the gain
// map, median of three, one-pole smoother, step quantizer and warm-up/poll
// logic predicts every output beat. Directed beats cover range ends, both
// request kinds and register corner values; random phases then drive drifting
// readings with spikes and polls under random register settings, with random
// gaps on input and output.
// ----------------------------------------------------------------------------
module tb_pot_median_smooth_quantizer;
    import pmsq_pkg::*;

    localparam longint UNIT      = 65536;
    localparam int     PHASES    = 8;
    localparam int     PHASE_LEN = 150;
    localparam int     DRAIN_CYC = 60;
    localparam logic [CFG_ADDR_W-1:0] REG_SPARE_LO = CFG_ADDR_W'(REG_WARMUP_LEN + 1);

    typedef enum bit {
        REQ_SAMPLE = 1'b0,
        REQ_POLL   = 1'b1
    } req_t;

    typedef struct {
        logic [STEP_W-1:0] step;
        logic [LVL_W-1:0]  level;
        logic              changed;
        logic              warming;
    } reading_t;

    class conditioner_board;
        longint   gain, reverse, coeff, warm_len;
        longint   hist[3];
        longint   level;
        longint   shown_step;
        bit       pending, warm_active;
        longint   warm_left;
        reading_t due[$];
        int       failures;

        function new();
            gain      = GAIN_RST;
            reverse   = 0;
            coeff     = COEFF_RST;
            warm_len  = WARMUP_RST;
            hist      = '{0, 0, 0};
            level     = 0;
            shown_step = 0;
            pending   = 0;
            failures  = 0;
            warm_left = warm_len;
            warm_active = (warm_len > 0);
        endfunction

        function longint to_unit(longint v);
            if (v < 0) return 0;
            if (v > UNIT) return UNIT;
            return v;
        endfunction

        function void write_reg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                REG_INPUT_GAIN:   gain = val[GAIN_W-1:0];
                REG_REVERSE_DIR:  reverse = val[0];
                REG_SMOOTH_COEFF: begin
                    coeff = val[LVL_W-1:0];
                    if (coeff > UNIT) coeff = UNIT;
                end
                REG_WARMUP_LEN: begin
                    warm_len    = val[WARM_W-1:0];
                    warm_left   = warm_len;
                    warm_active = (warm_len > 0);
                end
                default: ;
            endcase
        endfunction

        function void take_request(req_t req, logic [S_DATA_W-1:0] adc);
            reading_t r;
            longint   mapped, med, lo, hi, delta, nstep;
            if (req == REQ_POLL) begin
                r.changed = pending;
                pending   = 0;
            end else begin
                mapped = (longint'(adc) * gain) >>> 16;
                if (reverse != 0) mapped = UNIT - mapped;
                hist[2] = hist[1];
                hist[1] = hist[0];
                hist[0] = to_unit(mapped);
                lo = hist[0];
                hi = hist[0];
                for (int k = 1; k < 3; k++) begin
                    if (hist[k] < lo) lo = hist[k];
                    if (hist[k] > hi) hi = hist[k];
                end
                med   = hist[0] + hist[1] + hist[2] - lo - hi;
                delta = (coeff * (med - level) + 32768) >>> 16;
                level = to_unit(level + delta);
                nstep = (level >= UNIT) ? STEP_COUNT_DEF : ((level * STEP_COUNT_DEF) >>> 16);
                nstep = nstep & 'h7f;
                if (warm_active) begin
                    if (warm_left > 0) begin
                        warm_left--;
                    end else begin
                        warm_active = 0;
                        shown_step  = nstep;
                        pending     = 1;
                    end
                end else if (nstep != shown_step) begin
                    shown_step = nstep;
                    pending    = 1;
                end
                r.changed = pending;
            end
            r.step    = shown_step[STEP_W-1:0];
            r.level   = level[LVL_W-1:0];
            r.warming = warm_active;
            due.push_back(r);
        endfunction

        function void check_reading(logic [M_DATA_W-1:0] beat);
            reading_t e;
            if (due.size() == 0) begin
                $error("unexpected result beat %h", beat);
                failures++;
                return;
            end
            e = due.pop_front();
            if (beat[6:0] !== e.step) begin
                $error("step_value: expected %0d, actual %0d", e.step, beat[6:0]);
                failures++;
            end
            if (beat[23:7] !== e.level) begin
                $error("smoothed_level: expected %0d, actual %0d", e.level, beat[23:7]);
                failures++;
            end
            if (beat[24] !== e.changed) begin
                $error("change_flag: expected %0d, actual %0d", e.changed, beat[24]);
                failures++;
            end
            if (beat[25] !== e.warming) begin
                $error("warming_up: expected %0d, actual %0d", e.warming, beat[25]);
                failures++;
            end
        endfunction

        function bit busy();
            return due.size() != 0;
        endfunction
    endclass

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata = '0;
    logic                  s_tuser = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_DATA_W-1:0]   m_tdata;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_ADDR_W-1:0] cfg_addr = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    conditioner_board board = new();
    bit  idle_on = 1'b1;
    int  out_hold = 0;
    int  drift = 32768;

    pot_median_smooth_quantizer dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_addr  (cfg_addr),
        .cfg_data  (cfg_data)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) board.check_reading(m_tdata);
    end

    always @(negedge aclk) begin
        if (!idle_on) begin
            m_tready <= 1'b1;
        end else if (out_hold > 0) begin
            out_hold--;
            m_tready <= 1'b0;
        end else if ($urandom_range(99) < 70) begin
            m_tready <= 1'b1;
        end else begin
            out_hold = ($urandom_range(9) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 2);
            m_tready <= 1'b0;
        end
    end

    function automatic int pick_gap();
        int r;
        if (!idle_on) return 0;
        r = $urandom_range(99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // called at a falling edge; leaves at a falling edge
    task automatic send_item(input req_t req, input logic [S_DATA_W-1:0] adc, input int gap);
        s_tvalid <= 1'b1;
        s_tuser  <= req;
        s_tdata  <= adc;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        board.take_request(req, adc);
        @(negedge aclk);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (board.busy()) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_addr  <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        board.write_reg(idx, val);
        @(negedge aclk);
        cfg_valid <= 1'b0;
        @(negedge aclk);
    endtask

    // random upper bits ride along; the block keeps only the field width
    function automatic logic [CFG_DATA_W-1:0] with_junk(longint v, int width);
        logic [CFG_DATA_W-1:0] mask;
        mask = (32'h1 << width) - 1;
        return ($urandom & ~mask) | (CFG_DATA_W'(v) & mask);
    endfunction

    task automatic random_config();
        longint g, c, w;
        case ($urandom_range(9))
            0:       g = 0;
            1:       g = 262143;
            2:       g = $urandom_range(0, 262143);
            default: g = $urandom_range(40000, 140000);
        endcase
        case ($urandom_range(9))
            0:       c = 0;
            1:       c = UNIT;
            2:       c = $urandom_range(65537, 131071);
            3:       c = $urandom_range(1, 64);
            default: c = $urandom_range(1000, 65536);
        endcase
        case ($urandom_range(5))
            0:       w = 0;
            1:       w = $urandom_range(20, 80);
            default: w = $urandom_range(1, 6);
        endcase
        write_reg(REG_INPUT_GAIN, with_junk(g, GAIN_W));
        write_reg(REG_REVERSE_DIR, with_junk($urandom_range(1), 1));
        write_reg(REG_SMOOTH_COEFF, with_junk(c, LVL_W));
        if ($urandom_range(3) == 0)
            write_reg(CFG_ADDR_W'($urandom_range(REG_SPARE_LO, 255)), $urandom);
        write_reg(REG_WARMUP_LEN, with_junk(w, WARM_W));
    endtask

    function automatic logic [S_DATA_W-1:0] next_adc();
        int r;
        r = $urandom_range(99);
        if (r < 3) return ($urandom_range(1) != 0) ? 16'hffff : 16'h0000;
        if (r < 18) return S_DATA_W'($urandom);
        drift = drift + int'($urandom_range(0, 1600)) - 800;
        if (drift < 0) drift = 0;
        if (drift > 65535) drift = 65535;
        return drift[S_DATA_W-1:0];
    endfunction

    initial begin
        #2_000_000;
        $display("FAILED: results differ");
        $finish;
    end

    initial begin
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // reset values, long warm-up
        send_item(REQ_SAMPLE, 16'h0000, pick_gap());
        send_item(REQ_SAMPLE, 16'hffff, pick_gap());
        send_item(REQ_POLL, 16'hffff, pick_gap());
        send_item(REQ_SAMPLE, 16'd40000, pick_gap());
        drain();

        // short warm-up, then priming
        write_reg(REG_WARMUP_LEN, 32'd2);
        repeat (3) send_item(REQ_SAMPLE, 16'hffff, pick_gap());
        send_item(REQ_POLL, 16'h0000, pick_gap());
        send_item(REQ_POLL, 16'h5a5a, pick_gap());
        drain();

        // max gain, reversed, saturating coefficient, no warm-up
        write_reg(REG_INPUT_GAIN, 32'd262143);
        write_reg(REG_REVERSE_DIR, 32'd1);
        write_reg(REG_SMOOTH_COEFF, 32'h1ffff);
        write_reg(REG_WARMUP_LEN, 32'd0);
        send_item(REQ_SAMPLE, 16'h0000, pick_gap());
        send_item(REQ_SAMPLE, 16'hffff, pick_gap());
        send_item(REQ_SAMPLE, 16'hffff, pick_gap());
        send_item(REQ_SAMPLE, 16'h8000, pick_gap());
        send_item(REQ_POLL, 16'h0000, pick_gap());
        drain();

        // frozen filter, zero gain
        write_reg(REG_SMOOTH_COEFF, 32'd0);
        write_reg(REG_INPUT_GAIN, 32'd0);
        write_reg(REG_REVERSE_DIR, 32'd0);
        send_item(REQ_SAMPLE, 16'd12345, pick_gap());
        send_item(REQ_SAMPLE, 16'hffff, pick_gap());
        send_item(REQ_POLL, 16'h0000, pick_gap());
        drain();

        // longest warm-up, smallest nonzero coefficient, spare index ignored
        write_reg(REG_WARMUP_LEN, 32'd65535);
        write_reg(REG_SMOOTH_COEFF, 32'd1);
        write_reg(REG_INPUT_GAIN, 32'd65536);
        send_item(REQ_SAMPLE, 16'hffff, pick_gap());
        send_item(REQ_SAMPLE, 16'hffff, pick_gap());
        drain();
        write_reg(REG_SPARE_LO, 32'hffffffff);
        write_reg(8'hff, 32'h0);
        send_item(REQ_SAMPLE, 16'hffff, pick_gap());
        drain();

        for (int p = 0; p < PHASES; p++) begin
            idle_on = (p % 3) != 2;
            random_config();
            for (int i = 0; i < PHASE_LEN; i++) begin
                if ($urandom_range(99) == 0) drain();
                if ($urandom_range(99) < 15)
                    send_item(REQ_POLL, S_DATA_W'($urandom), pick_gap());
                else
                    send_item(REQ_SAMPLE, next_adc(), pick_gap());
            end
            drain();
        end

        repeat (DRAIN_CYC) @(posedge aclk);
        if (board.failures == 0 && !board.busy())
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
